### sv/btx_pkg.sv
`timescale 1ns / 1ps
// Shared types and default constants for the binary trie XOR-count unit.
// No dependencies.
package btx_pkg;

	localparam int MAX_NODES_DEF   = 65536;
	localparam int MAX_VALUES_DEF  = 65535;
	localparam int KEY_TOP_BIT_DEF = 30;

	localparam int KIND_W    = 2;
	localparam int COUNT_W   = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	// Control that travels down the cell row with a walk
	typedef struct packed {
		logic valid;  // a walk is at this cell
		logic ins;    // insert walk (else query)
		logic fresh;  // node just allocated: its entry reads as empty
		logic alive;  // query path still exists
	} ctl_t;

endpackage

### sv/btx_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/btx_cell.sv
`timescale 1ns / 1ps
// One trie level: node store for this depth, child allocation counter, insert and query step.
// Depends on btx_pkg and btx_ram.
module btx_cell #(
	parameter int NODE_W = 16,
	parameter int CNT_W  = 16,
	parameter int KEY_W  = 31,
	parameter int BIT    = 30,
	parameter bit LAST   = 1'b0,
	parameter int DEPTH  = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  btx_pkg::ctl_t     ctl_i,
	input  logic [NODE_W-1:0] addr_i,
	input  logic [KEY_W-1:0]  key_i,
	input  logic [KEY_W-1:0]  lim_i,
	input  logic [CNT_W-1:0]  total_i,
	output btx_pkg::ctl_t     ctl_o,
	output logic [NODE_W-1:0] addr_o,
	output logic [KEY_W-1:0]  key_o,
	output logic [KEY_W-1:0]  lim_o,
	output logic [CNT_W-1:0]  total_o,
	output logic              alloc
);

	localparam int ENT_W = 2 * NODE_W + 2 * CNT_W;

	btx_pkg::ctl_t     ctl_q;
	logic [NODE_W-1:0] addr_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  lim_q;
	logic [CNT_W-1:0]  total_q;
	logic [NODE_W-1:0] next_q;

	logic [ENT_W-1:0]  rdata;
	logic [ENT_W-1:0]  ent;
	logic [ENT_W-1:0]  wdata;
	logic [NODE_W-1:0] lnk_z, lnk_o, lnk_side, lnk_sel, child;
	logic [CNT_W-1:0]  cnt_z, cnt_o, cnt_x, cnt_sel, cnt_z_n, cnt_o_n;
	logic              x, y, sel, need_new, we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q  <= '0;
			next_q <= NODE_W'(1);
		end else begin
			ctl_q <= ctl_i;
			if (clr) begin
				next_q <= NODE_W'(1);
			end else if (alloc) begin
				next_q <= next_q + NODE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_i;
		key_q   <= key_i;
		lim_q   <= lim_i;
		total_q <= total_i;
	end

	btx_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_q),
		.wdata (wdata),
		.re    (ctl_i.valid & ctl_i.alive & ~ctl_i.fresh),
		.raddr (addr_i),
		.rdata (rdata)
	);

	always_comb begin
		ent = ctl_q.fresh ? '0 : rdata;
		{lnk_z, lnk_o, cnt_z, cnt_o} = ent;
		x        = key_q[BIT];
		y        = lim_q[BIT];
		sel      = x ^ y;
		cnt_x    = x ? cnt_o : cnt_z;
		// insert side; a leaf exists exactly when its count is nonzero
		lnk_side = x ? lnk_o : lnk_z;
		need_new = LAST ? (cnt_x == '0) : (lnk_side == '0);
		child    = need_new ? next_q : lnk_side;
		cnt_z_n  = x ? cnt_z : cnt_z + CNT_W'(1);
		cnt_o_n  = x ? cnt_o + CNT_W'(1) : cnt_o;
		wdata    = x ? {lnk_z, child, cnt_z_n, cnt_o_n}
		             : {child, lnk_o, cnt_z_n, cnt_o_n};
		we       = ctl_q.valid & ctl_q.ins;
		alloc    = we & need_new;
		// query side
		cnt_sel  = sel ? cnt_o : cnt_z;
		lnk_sel  = sel ? lnk_o : lnk_z;

		ctl_o.valid = ctl_q.valid;
		ctl_o.ins   = ctl_q.ins;
		key_o       = key_q;
		lim_o       = lim_q;
		if (ctl_q.ins) begin
			ctl_o.fresh = need_new;
			ctl_o.alive = 1'b1;
			addr_o      = child;
			total_o     = total_q;
		end else if (!ctl_q.alive) begin
			ctl_o.fresh = 1'b0;
			ctl_o.alive = 1'b0;
			addr_o      = addr_q;
			total_o     = total_q;
		end else begin
			ctl_o.fresh = 1'b0;
			ctl_o.alive = (lnk_sel != '0);
			addr_o      = lnk_sel;
			total_o     = total_q + (y ? cnt_x : '0) + (LAST ? cnt_sel : '0);
		end
	end

endmodule

### sv/binary_trie_xor_count_unit.sv
`timescale 1ns / 1ps
// Top level of the binary trie XOR-count unit: control, counters, cell row.
// Depends on btx_pkg and btx_cell.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-------------------------------
//  input   | in_valid/in_stall  | kind, value, limit
//  output  | out_valid/out_stall| match_count, status
//
// An insert or query walks one trie level per cycle down a row of
// KEY_TOP_BIT+1 cells, each owning the node store of its depth. Clear,
// unused kinds and refused inserts answer in the next cycle. One item is in
// flight at a time; in_stall stays high while a walk runs or a result waits,
// and drops the cycle after the result transfer. Reset empties the trie at
// once (no clearing pass): node stores are only read where written.
module binary_trie_xor_count_unit #(
	parameter int MAX_NODES   = btx_pkg::MAX_NODES_DEF,
	parameter int MAX_VALUES  = btx_pkg::MAX_VALUES_DEF,
	parameter int KEY_TOP_BIT = btx_pkg::KEY_TOP_BIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [btx_pkg::KIND_W-1:0]  kind,
	input  logic [KEY_TOP_BIT:0]        value,
	input  logic [KEY_TOP_BIT:0]        limit,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [btx_pkg::COUNT_W-1:0] match_count,
	output logic                        status
);

	localparam int LEVELS = KEY_TOP_BIT + 1;
	localparam int KEY_W  = KEY_TOP_BIT + 1;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int USED_W = $clog2(MAX_NODES + 1);
	localparam int CNT_W  = $clog2(MAX_VALUES + 1);

	btx_pkg::state_t state_q;
	logic [USED_W-1:0] nodes_used_q;
	logic [CNT_W-1:0]  values_q;
	logic              root_q;
	logic              start_q;
	logic              ins_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  lim_q;
	logic              out_valid_q;
	logic [btx_pkg::COUNT_W-1:0] match_q;
	logic              status_q;

	btx_pkg::ctl_t     ctl_w   [LEVELS+1];
	logic [NODE_W-1:0] addr_w  [LEVELS+1];
	logic [KEY_W-1:0]  key_w   [LEVELS+1];
	logic [KEY_W-1:0]  lim_w   [LEVELS+1];
	logic [CNT_W-1:0]  total_w [LEVELS+1];
	logic [LEVELS-1:0] alloc_w;

	logic accept, full, clr, done;
	btx_pkg::kind_t kind_in;

	assign kind_in  = btx_pkg::kind_t'(kind);
	assign in_stall = !state_q[0] | out_valid_q;
	assign accept   = in_valid & ~in_stall;
	// refuse when the value total is reached or too few nodes remain for a path
	assign full     = (values_q >= CNT_W'(MAX_VALUES))
	                || ((USED_W'(MAX_NODES) - nodes_used_q) < USED_W'(LEVELS));
	assign clr      = accept && (kind_in == btx_pkg::KIND_CLEAR);
	assign done     = ctl_w[LEVELS].valid;

	// launch the walk into the first cell (root is node 0)
	always_comb begin
		ctl_w[0].valid = start_q;
		ctl_w[0].ins   = ins_q;
		ctl_w[0].fresh = ~root_q;
		ctl_w[0].alive = 1'b1;
		addr_w[0]      = '0;
		key_w[0]       = key_q;
		lim_w[0]       = lim_q;
		total_w[0]     = '0;
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_cell
		btx_cell #(
			.NODE_W (NODE_W),
			.CNT_W  (CNT_W),
			.KEY_W  (KEY_W),
			.BIT    (KEY_TOP_BIT - k),
			.LAST   (k == LEVELS - 1),
			.DEPTH  (MAX_NODES)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (clr),
			.ctl_i   (ctl_w[k]),
			.addr_i  (addr_w[k]),
			.key_i   (key_w[k]),
			.lim_i   (lim_w[k]),
			.total_i (total_w[k]),
			.ctl_o   (ctl_w[k+1]),
			.addr_o  (addr_w[k+1]),
			.key_o   (key_w[k+1]),
			.lim_o   (lim_w[k+1]),
			.total_o (total_w[k+1]),
			.alloc   (alloc_w[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= btx_pkg::ST_IDLE;
			nodes_used_q <= USED_W'(1);
			values_q     <= '0;
			root_q       <= 1'b0;
			start_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (|alloc_w) begin
				nodes_used_q <= nodes_used_q + USED_W'(1);
			end
			// the root entry holds data once the first insert walk has passed it
			if (start_q && ins_q) begin
				root_q <= 1'b1;
			end
			case (state_q)
				btx_pkg::ST_IDLE: begin
					if (accept) begin
						case (kind_in)
							btx_pkg::KIND_INSERT: begin
								if (full) begin
									out_valid_q <= 1'b1;
								end else begin
									start_q  <= 1'b1;
									values_q <= values_q + CNT_W'(1);
									state_q  <= btx_pkg::ST_WALK;
								end
							end
							btx_pkg::KIND_QUERY: begin
								start_q <= 1'b1;
								state_q <= btx_pkg::ST_WALK;
							end
							btx_pkg::KIND_CLEAR: begin
								nodes_used_q <= USED_W'(1);
								values_q     <= '0;
								root_q       <= 1'b0;
								out_valid_q  <= 1'b1;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				btx_pkg::ST_WALK: begin
					if (done) begin
						out_valid_q <= 1'b1;
						state_q     <= btx_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= btx_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// result payload: hold the item fields, then the walk outcome
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q    <= (kind_in == btx_pkg::KIND_INSERT);
			key_q    <= value;
			lim_q    <= limit;
			match_q  <= '0;
			status_q <= (kind_in == btx_pkg::KIND_INSERT) && full;
		end else if (done) begin
			match_q <= ctl_w[LEVELS].ins ? '0
			                             : btx_pkg::COUNT_W'(total_w[LEVELS]);
		end
	end

	assign out_valid   = out_valid_q;
	assign match_count = match_q;
	assign status      = status_q;

endmodule
